/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TDAT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TDAT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tdat_pkg.sv */
package tdat_pkg;

	localparam int unsigned MAX_HOUR   = 23;
	localparam int unsigned MAX_MINUTE = 59;
	localparam int unsigned FIRED_W    = 8;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_BAD_TIM = 2'd2,
		STAT_NO_IDX  = 2'd3
	} status_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic       rep;
		logic       en;
		logic       trig;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK_RD,
		ST_TICK_WR,
		ST_REM_RD,
		ST_REM_WR,
		ST_READ_RD,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic cap;       // latch the accepted beat, clear result
		logic mem_rd;    // read table at pointer (or pointer + 1)
		logic rd_next;   // read address is pointer + 1
		logic tick_wr;   // match/re-arm the read entry, write back
		logic copy_wr;   // write read entry one place down
		logic add_do;    // check and append a new entry
		logic rem_fin;   // drop the last entry
		logic read_out;  // present the read entry
		logic set_no_idx;
		logic ptr_inc;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		mode_t mode;
		logic  idx_ok;     // index below entry count
		logic  cur_out;    // pointer at or past the entry count
		logic  next_out;   // pointer + 1 at or past the entry count
		logic  next2_out;  // pointer + 2 at or past the entry count
	} stat_t;

endpackage

/* rtl/tdat_ctrl.sv */
`include "assert_macros.svh"

module tdat_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  tdat_pkg::stat_t st,
	output tdat_pkg::cmd_t  cmd
);

	tdat_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			tdat_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.cap = 1'b1;
					state_d = tdat_pkg::ST_DECODE;
				end
			end
			tdat_pkg::ST_DECODE: begin
				case (st.mode)
					tdat_pkg::MODE_TICK: begin
						state_d = st.cur_out ? tdat_pkg::ST_DONE : tdat_pkg::ST_TICK_RD;
					end
					tdat_pkg::MODE_ADD: begin
						cmd.add_do = 1'b1;
						state_d    = tdat_pkg::ST_DONE;
					end
					tdat_pkg::MODE_REMOVE: begin
						if (!st.idx_ok) begin
							cmd.set_no_idx = 1'b1;
							state_d        = tdat_pkg::ST_DONE;
						end else if (st.next_out) begin
							cmd.rem_fin = 1'b1;
							state_d     = tdat_pkg::ST_DONE;
						end else begin
							state_d = tdat_pkg::ST_REM_RD;
						end
					end
					default: begin
						if (!st.idx_ok) begin
							cmd.set_no_idx = 1'b1;
							state_d        = tdat_pkg::ST_DONE;
						end else begin
							// pointer already holds the index; start the table read
							cmd.mem_rd = 1'b1;
							state_d    = tdat_pkg::ST_READ_RD;
						end
					end
				endcase
			end
			tdat_pkg::ST_TICK_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = tdat_pkg::ST_TICK_WR;
			end
			tdat_pkg::ST_TICK_WR: begin
				cmd.tick_wr = 1'b1;
				if (st.next_out) begin
					state_d = tdat_pkg::ST_DONE;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = tdat_pkg::ST_TICK_RD;
				end
			end
			tdat_pkg::ST_REM_RD: begin
				cmd.mem_rd  = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = tdat_pkg::ST_REM_WR;
			end
			tdat_pkg::ST_REM_WR: begin
				cmd.copy_wr = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (st.next2_out) begin
					cmd.rem_fin = 1'b1;
					state_d     = tdat_pkg::ST_DONE;
				end else begin
					state_d = tdat_pkg::ST_REM_RD;
				end
			end
			tdat_pkg::ST_READ_RD: begin
				// read data is in its register now; move it to the result
				cmd.read_out = 1'b1;
				state_d      = tdat_pkg::ST_DONE;
			end
			tdat_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = tdat_pkg::ST_IDLE;
			end
			default: begin
				state_d = tdat_pkg::ST_IDLE;
			end
		endcase
	end

	`TDAT_ASSERT(a_done_one_cycle, clk, arst_n, done |=> !done, "result strobe held longer than one cycle")
	`TDAT_ASSERT(a_accept_goes_busy, clk, arst_n, (start && !busy) |=> (busy && !done), "accepted beat did not start work")

endmodule

/* rtl/tdat_dpath.sv */
`include "assert_macros.svh"

module tdat_dpath #(
	parameter int unsigned TABLE_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tdat_pkg::cmd_t   cmd,
	output tdat_pkg::stat_t  st,
	input  logic [1:0]       mode,
	input  logic [4:0]       hour,
	input  logic [5:0]       minute,
	input  logic             repeat_req,
	input  logic [2:0]       index,
	output logic [1:0]       status,
	output logic [7:0]       fired_mask,
	output logic [3:0]       entry_count,
	output logic [4:0]       entry_hour,
	output logic [5:0]       entry_minute,
	output logic             entry_repeat,
	output logic             entry_enabled,
	output logic             entry_triggered
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	// compare width also holds the full 3-bit index
	localparam int unsigned XW = (CW > 3) ? CW + 1 : 4;

	// Latched beat
	tdat_pkg::mode_t mode_q;
	logic [4:0]      hour_q;
	logic [5:0]      minute_q;
	logic            rep_q;
	logic [2:0]      idx_q;

	logic [CW-1:0]   count_q;
	logic [AW-1:0]   ptr_q;
	tdat_pkg::entry_t mem_q [TABLE_DEPTH];
	tdat_pkg::entry_t rd_data_q;

	tdat_pkg::status_t status_q;
	logic [tdat_pkg::FIRED_W-1:0] fired_q;
	tdat_pkg::entry_t out_q;

	logic [XW-1:0] ptr_x, ptr1_x, ptr2_x, cnt_x;
	logic          add_full, add_bad;
	logic          match;
	tdat_pkg::entry_t tick_e;
	logic          mem_we;
	logic [AW-1:0] wr_addr, rd_addr;
	tdat_pkg::entry_t wr_data;

	// Pointer and count compares
	assign ptr_x  = XW'(ptr_q);
	assign ptr1_x = ptr_x + XW'(1);
	assign ptr2_x = ptr_x + XW'(2);
	assign cnt_x  = XW'(count_q);

	assign st.mode      = mode_q;
	assign st.idx_ok    = XW'(idx_q) < cnt_x;
	assign st.cur_out   = ptr_x >= cnt_x;
	assign st.next_out  = ptr1_x >= cnt_x;
	assign st.next2_out = ptr2_x >= cnt_x;

	// Add checks: full before time range
	assign add_full = cnt_x >= XW'(TABLE_DEPTH);
	assign add_bad  = (32'(hour_q) > tdat_pkg::MAX_HOUR) ||
	                  (32'(minute_q) > tdat_pkg::MAX_MINUTE);

	// Tick update of the entry just read
	assign match = (rd_data_q.hour == hour_q) && (rd_data_q.minute == minute_q);
	always_comb begin
		tick_e = rd_data_q;
		if (rd_data_q.en) begin
			if (match) begin
				if (!rd_data_q.trig) begin
					tick_e.trig = 1'b1;
					if (!rd_data_q.rep) begin
						tick_e.en = 1'b0;
					end
				end
			end else begin
				tick_e.trig = 1'b0;
			end
		end
	end

	// Table write port
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = ptr_q;
		wr_data = rd_data_q;
		if (cmd.tick_wr) begin
			mem_we  = 1'b1;
			wr_data = tick_e;
		end else if (cmd.copy_wr) begin
			mem_we = 1'b1;
		end else if (cmd.add_do && !add_full && !add_bad) begin
			mem_we  = 1'b1;
			wr_addr = AW'(count_q);
			wr_data = '{hour: hour_q, minute: minute_q, rep: rep_q, en: 1'b1, trig: 1'b0};
		end
	end

	assign rd_addr = cmd.rd_next ? AW'(ptr1_x) : ptr_q;

	// Table storage, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Entry count and walk pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.add_do && !add_full && !add_bad) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rem_fin) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.cap) begin
				ptr_q <= (tdat_pkg::mode_t'(mode) == tdat_pkg::MODE_TICK) ? '0 : AW'(index);
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// Beat latch and result registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q   <= tdat_pkg::mode_t'(mode);
			hour_q   <= hour;
			minute_q <= minute;
			rep_q    <= repeat_req;
			idx_q    <= index;
			status_q <= tdat_pkg::STAT_OK;
			fired_q  <= '0;
			out_q    <= '0;
		end else begin
			if (cmd.add_do) begin
				if (add_full) begin
					status_q <= tdat_pkg::STAT_FULL;
				end else if (add_bad) begin
					status_q <= tdat_pkg::STAT_BAD_TIM;
				end
			end
			if (cmd.set_no_idx) begin
				status_q <= tdat_pkg::STAT_NO_IDX;
			end
			// only the first eight positions show in the mask
			if (cmd.tick_wr && rd_data_q.en && match && !rd_data_q.trig &&
			    (int'(ptr_q) < tdat_pkg::FIRED_W)) begin
				fired_q[3'(ptr_q)] <= 1'b1;
			end
			if (cmd.read_out) begin
				out_q <= rd_data_q;
			end
		end
	end

	assign status          = status_q;
	assign fired_mask      = fired_q;
	assign entry_count     = 4'(count_q);
	assign entry_hour      = out_q.hour;
	assign entry_minute    = out_q.minute;
	assign entry_repeat    = out_q.rep;
	assign entry_enabled   = out_q.en;
	assign entry_triggered = out_q.trig;

	`TDAT_ASSERT(a_count_bound, clk, arst_n, cnt_x <= XW'(TABLE_DEPTH), "entry count above table depth")
	`TDAT_ASSERT(a_tick_keeps_count, clk, arst_n, cmd.tick_wr |=> $stable(count_q), "tick changed the entry count")

endmodule

/* rtl/time_of_day_alarm_table.sv */
// Hour:minute alarm table.
// Command channel: a beat (mode, hour, minute, repeat_req, index) is taken on
// a rising edge with start high and busy low. busy stays high until the
// result has been shown.
// Result channel: done is high for exactly one cycle with status, fired_mask,
// entry_count and the entry_* fields valid in that cycle. The receiver
// cannot stall; the result fields hold until the next beat is accepted.
// Work per beat, before start can be taken again:
//   add, read, and remove past the end or of the last entry: no table walk;
//   remove at index i: walk over entries i+1 to count-1; tick: walk over all entries.
// Each step of the table walk reads one entry and then writes one entry,
// in separate controller states.
// Reset clears the entry count and the controller; table contents are not
// cleared, since entries at or past the count are never seen.
`include "assert_macros.svh"

module time_of_day_alarm_table #(
	parameter int unsigned TABLE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	input  logic [1:0] mode,
	input  logic [4:0] hour,
	input  logic [5:0] minute,
	input  logic       repeat_req,
	input  logic [2:0] index,
	output logic [1:0] status,
	output logic [7:0] fired_mask,
	output logic [3:0] entry_count,
	output logic [4:0] entry_hour,
	output logic [5:0] entry_minute,
	output logic       entry_repeat,
	output logic       entry_enabled,
	output logic       entry_triggered
);

	tdat_pkg::cmd_t  cmd;
	tdat_pkg::stat_t st;

	tdat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.st     (st),
		.cmd    (cmd)
	);

	tdat_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.mode            (mode),
		.hour            (hour),
		.minute          (minute),
		.repeat_req      (repeat_req),
		.index           (index),
		.status          (status),
		.fired_mask      (fired_mask),
		.entry_count     (entry_count),
		.entry_hour      (entry_hour),
		.entry_minute    (entry_minute),
		.entry_repeat    (entry_repeat),
		.entry_enabled   (entry_enabled),
		.entry_triggered (entry_triggered)
	);

	`TDAT_ASSERT(a_done_while_busy, clk, arst_n, done |-> busy, "result strobe outside a busy period")
	`TDAT_ASSERT(a_done_then_idle, clk, arst_n, done |=> !busy, "not idle after the result beat")

endmodule

/* tb/sv/testbench.sv */
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int SLOT_COUNT = 8;

	// Expected result of one beat
	typedef struct packed {
		tdat_pkg::status_t status;
		logic [7:0] fired;
		logic [3:0] count;
		logic [4:0] hour;
		logic [5:0] minute;
		logic       rep;
		logic       en;
		logic       trig;
	} alarm_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic       done;
	logic [1:0] mode = tdat_pkg::MODE_TICK;
	logic [4:0] hour = '0;
	logic [5:0] minute = '0;
	logic       repeat_req = 1'b0;
	logic [2:0] index = '0;
	logic [1:0] status;
	logic [7:0] fired_mask;
	logic [3:0] entry_count;
	logic [4:0] entry_hour;
	logic [5:0] entry_minute;
	logic       entry_repeat;
	logic       entry_enabled;
	logic       entry_triggered;

	// Shadow copy of the alarm table
	tdat_pkg::entry_t alarm_slots [SLOT_COUNT];
	int unsigned alarm_count = 0;

	alarm_result_t pending_results [$];
	alarm_result_t want;

	int  mismatch_count = 0;
	int  beats_sent = 0;
	int  results_seen = 0;
	int  firing_ticks = 0;
	int  rejected_adds = 0;
	int  cycle_count = 0;
	bit  idle_on = 1'b1;

	time_of_day_alarm_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.done            (done),
		.mode            (mode),
		.hour            (hour),
		.minute          (minute),
		.repeat_req      (repeat_req),
		.index           (index),
		.status          (status),
		.fired_mask      (fired_mask),
		.entry_count     (entry_count),
		.entry_hour      (entry_hour),
		.entry_minute    (entry_minute),
		.entry_repeat    (entry_repeat),
		.entry_enabled   (entry_enabled),
		.entry_triggered (entry_triggered)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Applies one beat to the shadow table and returns what the block must report.
	function automatic alarm_result_t apply_alarm_op(tdat_pkg::mode_t op, logic [4:0] h,
			logic [5:0] m, logic r, logic [2:0] idx);
		alarm_result_t res;
		int unsigned   i;
		res = '0;
		res.status = tdat_pkg::STAT_OK;
		case (op)
			tdat_pkg::MODE_TICK: begin
				for (i = 0; i < alarm_count; i++) begin
					if (alarm_slots[i].en) begin
						if (alarm_slots[i].hour == h && alarm_slots[i].minute == m) begin
							if (!alarm_slots[i].trig) begin
								alarm_slots[i].trig = 1'b1;
								res.fired[i] = 1'b1;
								// one-shot alarms switch themselves off
								if (!alarm_slots[i].rep)
									alarm_slots[i].en = 1'b0;
							end
						end else begin
							alarm_slots[i].trig = 1'b0;
						end
					end
				end
				if (res.fired != '0)
					firing_ticks++;
			end
			tdat_pkg::MODE_ADD: begin
				// full check wins over the time check
				if (alarm_count >= SLOT_COUNT) begin
					res.status = tdat_pkg::STAT_FULL;
					rejected_adds++;
				end else if (h > tdat_pkg::MAX_HOUR || m > tdat_pkg::MAX_MINUTE) begin
					res.status = tdat_pkg::STAT_BAD_TIM;
					rejected_adds++;
				end else begin
					alarm_slots[alarm_count] = '{hour: h, minute: m, rep: r, en: 1'b1,
						trig: 1'b0};
					alarm_count++;
				end
			end
			tdat_pkg::MODE_REMOVE: begin
				if (idx >= alarm_count) begin
					res.status = tdat_pkg::STAT_NO_IDX;
				end else begin
					for (i = idx; i + 1 < alarm_count; i++)
						alarm_slots[i] = alarm_slots[i + 1];
					alarm_count--;
					alarm_slots[alarm_count].en = 1'b0;
				end
			end
			default: begin
				if (idx >= alarm_count) begin
					res.status = tdat_pkg::STAT_NO_IDX;
				end else begin
					res.hour = alarm_slots[idx].hour;
					res.minute = alarm_slots[idx].minute;
					res.rep = alarm_slots[idx].rep;
					res.en = alarm_slots[idx].en;
					res.trig = alarm_slots[idx].trig;
				end
			end
		endcase
		res.count = alarm_count[3:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
		$display("MISMATCH result %0d %s: got %h, want %h", results_seen, what, got, exp_val);
		mismatch_count++;
	endtask

	task automatic check_field(string what, logic [7:0] got, logic [7:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	// Result monitor: every done strobe is one result beat
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {6'd0, status}, 8'd0);
			end else begin
				want = pending_results.pop_front();
				check_field("status", {6'd0, status}, {6'd0, want.status});
				check_field("fired_mask", fired_mask, want.fired);
				check_field("entry_count", {4'd0, entry_count}, {4'd0, want.count});
				check_field("entry_hour", {3'd0, entry_hour}, {3'd0, want.hour});
				check_field("entry_minute", {2'd0, entry_minute}, {2'd0, want.minute});
				check_field("entry_repeat", {7'd0, entry_repeat}, {7'd0, want.rep});
				check_field("entry_enabled", {7'd0, entry_enabled}, {7'd0, want.en});
				check_field("entry_triggered", {7'd0, entry_triggered}, {7'd0, want.trig});
			end
			results_seen++;
		end
	end

	function automatic int idle_gap();
		if (!idle_on || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 8);
	endfunction

	// Drives one beat and holds it until accepted; called at a rising edge.
	task automatic send_beat(tdat_pkg::mode_t op, logic [4:0] h, logic [5:0] m, logic r,
			logic [2:0] idx);
		int gap;
		mode <= op;
		hour <= h;
		minute <= m;
		repeat_req <= r;
		index <= idx;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_alarm_op(op, h, m, r, idx));
		beats_sent++;
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Reads and removes on an empty table, and a tick with nothing to match
	task automatic test_empty_table();
		send_beat(tdat_pkg::MODE_READ, 5'd31, 6'd63, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_REMOVE, 5'd0, 6'd0, 1'b0, 3'd7);
		send_beat(tdat_pkg::MODE_TICK, 5'd0, 6'd0, 1'b0, 3'd0);
	endtask

	// Time validation on add, and the extreme valid times
	task automatic test_add_checks();
		send_beat(tdat_pkg::MODE_ADD, 5'd24, 6'd0, 1'b0, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd0, 6'd60, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd31, 6'd63, 1'b1, 3'd7);
		send_beat(tdat_pkg::MODE_ADD, 5'd0, 6'd0, 1'b0, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd23, 6'd59, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd12, 6'd30, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd12, 6'd30, 1'b0, 3'd0);
	endtask

	// Fire once, no refire while matching, re-arm, one-shot stays off
	task automatic test_tick_behavior();
		send_beat(tdat_pkg::MODE_TICK, 5'd12, 6'd30, 1'b0, 3'd0);
		send_beat(tdat_pkg::MODE_TICK, 5'd12, 6'd30, 1'b1, 3'd5);
		send_beat(tdat_pkg::MODE_READ, 5'd0, 6'd0, 1'b0, 3'd3);
		send_beat(tdat_pkg::MODE_TICK, 5'd31, 6'd63, 1'b0, 3'd0);
		send_beat(tdat_pkg::MODE_READ, 5'd0, 6'd0, 1'b0, 3'd3);
		send_beat(tdat_pkg::MODE_TICK, 5'd12, 6'd30, 1'b0, 3'd0);
	endtask

	// Fill the table, add when full, then shift on removes
	task automatic test_full_and_remove();
		send_beat(tdat_pkg::MODE_ADD, 5'd5, 6'd5, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd6, 6'd6, 1'b0, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd7, 6'd7, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd8, 6'd8, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_ADD, 5'd31, 6'd63, 1'b1, 3'd0);
		send_beat(tdat_pkg::MODE_READ, 5'd0, 6'd0, 1'b0, 3'd7);
		send_beat(tdat_pkg::MODE_REMOVE, 5'd0, 6'd0, 1'b0, 3'd2);
		send_beat(tdat_pkg::MODE_REMOVE, 5'd0, 6'd0, 1'b0, 3'd6);
		send_beat(tdat_pkg::MODE_REMOVE, 5'd0, 6'd0, 1'b0, 3'd7);
		send_beat(tdat_pkg::MODE_TICK, 5'd23, 6'd59, 1'b0, 3'd0);
		send_beat(tdat_pkg::MODE_READ, 5'd0, 6'd0, 1'b0, 3'd0);
	endtask

	// Random mix, biased so that ticks often hit stored times
	task automatic test_random_ops(int beats, bit allow_idle);
		int          k;
		int          sel;
		int          p_add;
		int          p_rem;
		int unsigned pick;
		logic [4:0]  h;
		logic [5:0]  m;
		logic [2:0]  idx;
		tdat_pkg::mode_t op;
		for (k = 0; k < beats; k++) begin
			// idle stretches come and go
			if (k % 64 == 0)
				idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			p_add = (alarm_count < 5) ? 40 : 22;
			p_rem = (alarm_count < 5) ? 12 : 28;
			sel = $urandom_range(0, 99);
			h = 5'($urandom_range(0, 31));
			m = 6'($urandom_range(0, 63));
			idx = 3'($urandom_range(0, 7));
			if (sel < p_add) begin
				op = tdat_pkg::MODE_ADD;
				if ($urandom_range(0, 99) < 85) begin
					// clustered times make several entries fire together
					if ($urandom_range(0, 1) == 0) begin
						h = 5'($urandom_range(0, 2));
						m = 6'($urandom_range(0, 2));
					end else begin
						h = 5'($urandom_range(0, tdat_pkg::MAX_HOUR));
						m = 6'($urandom_range(0, tdat_pkg::MAX_MINUTE));
					end
				end
			end else if (sel < p_add + p_rem) begin
				op = tdat_pkg::MODE_REMOVE;
				if (alarm_count > 0 && $urandom_range(0, 4) != 0)
					idx = 3'($urandom_range(0, alarm_count - 1));
			end else if (sel < p_add + p_rem + 15) begin
				op = tdat_pkg::MODE_READ;
				if (alarm_count > 0 && $urandom_range(0, 4) != 0)
					idx = 3'($urandom_range(0, alarm_count - 1));
			end else begin
				op = tdat_pkg::MODE_TICK;
				pick = $urandom_range(0, 99);
				if (alarm_count > 0 && pick < 60) begin
					pick = $urandom_range(0, alarm_count - 1);
					h = alarm_slots[pick].hour;
					m = alarm_slots[pick].minute;
				end else if (pick < 85) begin
					h = 5'($urandom_range(0, 2));
					m = 6'($urandom_range(0, 2));
				end
			end
			send_beat(op, h, m, 1'($urandom_range(0, 1)), idx);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_add_checks();
		test_tick_behavior();
		test_full_and_remove();
		test_random_ops(800, 1'b1);
		// back-to-back tail, no idling
		idle_on = 1'b0;
		test_random_ops(100, 1'b0);
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", 8'(pending_results.size()), 8'd0);

		$display("Sent %0d beats and checked %0d results over %0d cycles.", beats_sent,
			results_seen, cycle_count);
		$display("%0d ticks fired at least one alarm; %0d adds were rejected.", firing_ticks,
			rejected_adds);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
